>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/sll_pkg.sv
// ---------------------------------------------------------------------------
// sll_pkg
// token kinds, keyword table and the token record shared by the lexer parts
// ---------------------------------------------------------------------------
`default_nettype none
package sll_pkg;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_INST   = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } sll_kind_t;

  localparam int unsigned NUM_KW      = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // keyword spellings, unused slots zero
  localparam logic [7:0] KW_TEXT [NUM_KW][4] = '{
    '{8'h70, 8'h75, 8'h73, 8'h68},   // push
    '{8'h68, 8'h6c, 8'h74, 8'h00},   // hlt
    '{8'h61, 8'h64, 8'h64, 8'h00}    // add
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd3, 3'd3};

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;

  // token as classified by the front end
  typedef struct packed {
    sll_kind_t   kind;
    logic [31:0] magnitude;  // digit value, or opcode for instructions
    logic        negative;
    logic [15:0] line;
    logic        fin;
  } sll_tok_t;

endpackage
`default_nettype wire

>>> rtl/sll_front.sv
// ---------------------------------------------------------------------------
// sll_front
// byte scanner: gathers lexemes, converts digits, matches keywords
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sll_front #(
  parameter int unsigned MAX_LEXEME_LEN = 255,
  parameter int unsigned LINE_BITS      = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  input  wire logic [7:0]       src_byte,
  output sll_pkg::sll_tok_t     tok,
  output logic                  tok_valid
);
  import sll_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEXEME_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEXEME_LEN);

  logic [LW-1:0]        len, len_next;
  logic [31:0]          acc, acc_next;
  logic                 is_num, is_num_next;
  logic                 neg, neg_next;
  logic                 stopped, stopped_next;
  logic                 sign_ok, sign_ok_next;
  logic [NUM_KW-1:0]    cand, cand_next;
  logic [LINE_BITS-1:0] line_cnt, line_cnt_next;

  logic        is_delim, is_digit, is_ws, is_sign;
  logic        op_found;
  logic [1:0]  op;
  logic [15:0] line16;

  if (LINE_BITS >= 16) begin : g_line_wide
    assign line16 = line_cnt[15:0];
  end else begin : g_line_narrow
    assign line16 = {{(16 - LINE_BITS){1'b0}}, line_cnt};
  end

  assign is_delim = (src_byte == CH_SPACE) || (src_byte == CH_NL) || (src_byte == CH_NUL);
  assign is_digit = (src_byte >= CH_ZERO) && (src_byte <= CH_NINE);
  assign is_ws    = (src_byte == CH_TAB) || (src_byte == CH_VT) ||
                    (src_byte == CH_FF) || (src_byte == CH_CR);
  assign is_sign  = (src_byte == CH_PLUS) || (src_byte == CH_MINUS);

  always_comb begin
    op_found = 1'b0;
    op       = 2'd0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && (len == {{(LW-3){1'b0}}, KW_LEN[k]})) begin
        op_found = 1'b1;
        op       = 2'(k);
      end
    end
  end

  always_comb begin
    len_next      = len;
    acc_next      = acc;
    is_num_next   = is_num;
    neg_next      = neg;
    stopped_next  = stopped;
    sign_ok_next  = sign_ok;
    cand_next     = cand;
    line_cnt_next = line_cnt;
    tok_valid     = 1'b0;
    tok.kind      = KIND_END;
    tok.magnitude = '0;
    tok.negative  = 1'b0;
    tok.line      = line16;
    tok.fin       = 1'b0;

    if (byte_valid) begin
      if (!is_delim) begin
        if (len == LEN_MAX) begin
          tok_valid = 1'b1;
          tok.kind  = KIND_ERROR;
        end else begin
          if ((len == '0) && (src_byte == CH_HASH)) begin
            is_num_next = 1'b1;
          end else if (is_num && !stopped) begin
            if (sign_ok && is_ws) begin
              acc_next = acc;
            end else if (sign_ok && is_sign) begin
              neg_next     = (src_byte == CH_MINUS);
              sign_ok_next = 1'b0;
            end else if (is_digit) begin
              acc_next     = (acc << 3) + (acc << 1) + {28'd0, src_byte[3:0]};
              sign_ok_next = 1'b0;
            end else begin
              stopped_next = 1'b1;
            end
          end
          for (int k = 0; k < NUM_KW; k++) begin
            if ((len >= {{(LW-3){1'b0}}, KW_LEN[k]}) || (KW_TEXT[k][len[1:0]] != src_byte))
              cand_next[k] = 1'b0;
          end
          len_next = len + 1'b1;
        end
      end else begin
        tok_valid = 1'b1;
        tok.fin   = (src_byte == CH_NUL);
        if (len == '0) begin
          tok.kind = KIND_END;
          tok.fin  = 1'b1;
        end else if (is_num) begin
          tok.kind      = KIND_NUMBER;
          tok.magnitude = acc;
          tok.negative  = neg;
        end else if (op_found) begin
          tok.kind      = KIND_INST;
          tok.magnitude = {30'd0, op};
        end else begin
          tok.kind = KIND_ERROR;
        end
      end
    end

    // lexeme restart after a token, full restart after end, error or nul
    if (tok_valid) begin
      len_next     = '0;
      acc_next     = '0;
      is_num_next  = 1'b0;
      neg_next     = 1'b0;
      stopped_next = 1'b0;
      sign_ok_next = 1'b1;
      cand_next    = '1;
      if ((tok.kind == KIND_ERROR) || (tok.kind == KIND_END) || tok.fin)
        line_cnt_next = LINE_BITS'(1);
      else if (src_byte == CH_NL)
        line_cnt_next = line_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      acc      <= '0;
      is_num   <= 1'b0;
      neg      <= 1'b0;
      stopped  <= 1'b0;
      sign_ok  <= 1'b1;
      cand     <= '1;
      line_cnt <= LINE_BITS'(1);
    end else begin
      len      <= len_next;
      acc      <= acc_next;
      is_num   <= is_num_next;
      neg      <= neg_next;
      stopped  <= stopped_next;
      sign_ok  <= sign_ok_next;
      cand     <= cand_next;
      line_cnt <= line_cnt_next;
    end
  end

  `ASSERT_ALWAYS(a_len_in_range, clk, rst, len <= LEN_MAX)
  `ASSERT_NEXT(a_token_clears, clk, rst, tok_valid, (len == '0) && (cand == '1))

endmodule
`default_nettype wire

>>> rtl/sll_queue.sv
// ---------------------------------------------------------------------------
// sll_queue
// short token queue between scanner and result stage
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sll_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  sll_pkg::sll_tok_t      wr_data,
  output logic                   full,
  input  wire logic              rd,
  output sll_pkg::sll_tok_t      rd_data,
  output logic                   empty
);
  import sll_pkg::*;

  sll_tok_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_wr, do_rd;

  assign full    = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_count_up, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1)

endmodule
`default_nettype wire

>>> rtl/sll_back.sv
// ---------------------------------------------------------------------------
// sll_back
// result stage: applies the sign, forms the value and holds the result
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sll_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  sll_pkg::sll_tok_t  q_data,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [1:0]         token_kind,
  output logic [31:0]        token_value,
  output logic [15:0]        line_number,
  output logic               final_res
);
  import sll_pkg::*;

  logic        out_valid;
  logic [31:0] value;

  assign empty = !out_valid;
  assign q_pop = !q_empty && (!out_valid || pop);

  always_comb begin
    unique case (q_data.kind)
      KIND_NUMBER: value = q_data.negative ? (32'd0 - q_data.magnitude) : q_data.magnitude;
      KIND_INST:   value = q_data.magnitude;
      KIND_ERROR,
      KIND_END:    value = 32'd0;
      default:     value = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      token_kind  <= q_data.kind;
      token_value <= value;
      line_number <= q_data.line;
      final_res   <= q_data.fin;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_load_shows, clk, rst, q_pop, out_valid)
  `ASSERT_NEXT(a_hold_waiting, clk, rst, out_valid && !pop, out_valid)

endmodule
`default_nettype wire

>>> rtl/stack_language_lexer.sv
// ---------------------------------------------------------------------------
// stack_language_lexer
// lexer for a small stack language, one source byte per transaction
// ---------------------------------------------------------------------------
//
//  channel   handshake        payload
//  source    push / full      src_byte
//  tokens    pop / empty      token_kind, token_value, line_number, final_res
//
//  one byte is taken every cycle while the token queue has room; a token
//  enters the queue at the edge that takes its ending delimiter and then the
//  result register, later while older tokens still wait there
//  the scanner's per-byte update (digit times ten plus keyword compare) sets
//  the cycle, the queue and the result register part it from the consumer
//  reset is synchronous: scanner state to its start values, line count one
//  full rises only when the queue is full with the result register held
//
`default_nettype none
module stack_language_lexer #(
  parameter int unsigned MAX_LEXEME_LEN = 255,
  parameter int unsigned LINE_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  src_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       token_kind,
  output logic [31:0]      token_value,
  output logic [15:0]      line_number,
  output logic             final_res
);
  import sll_pkg::*;

  sll_tok_t front_tok, q_data;
  logic     front_valid;
  logic     q_empty, q_pop;

  // front end: scanner, runs on every accepted byte
  sll_front #(
    .MAX_LEXEME_LEN (MAX_LEXEME_LEN),
    .LINE_BITS      (LINE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (push && !full),
    .src_byte   (src_byte),
    .tok        (front_tok),
    .tok_valid  (front_valid)
  );

  // decoupling queue, its full flag stalls the source
  sll_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_valid),
    .wr_data (front_tok),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // back end: value formation and result register
  sll_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .token_kind  (token_kind),
    .token_value (token_value),
    .line_number (line_number),
    .final_res   (final_res)
  );

endmodule
`default_nettype wire
